// ===== hdl/lpp_pkg.sv =====
// Shared types and constants of the distance packet parser.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package lpp_pkg;

	localparam int TABLE_ANGLES_DEF = 360;
	localparam int PACKET_BYTES     = 22;
	localparam int READINGS         = 4;
	localparam int DIST_W           = 14;
	localparam int DIST_HI_W        = 6;
	localparam int ANGLE_W          = 9;
	localparam int POS_W            = 5;
	localparam int CSUM_W           = 26;
	localparam int CSUM_FOLD        = 15;
	localparam int CNT_W            = 16;
	localparam int COVER_W          = 9;
	localparam int INV_BIT          = 7;
	localparam int WARN_BIT         = 6;
	localparam int CSUM_BYTES_AT    = 20;    // first checksum byte position
	localparam int BAD_CSUM_PENALTY = 4;

	localparam logic [7:0] START_BYTE = 8'hFA;
	localparam logic [7:0] INDEX_BASE = 8'hA0;
	localparam logic [7:0] INDEX_LAST = 8'hF9;

	typedef enum logic {
		CMD_BYTE = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	typedef enum logic {
		KIND_SUMMARY = 1'b0,
		KIND_READ    = 1'b1
	} kind_t;

	// table update request, issued once per complete packet with a valid index
	typedef struct packed {
		logic                               valid;
		logic [ANGLE_W-1:0]                 start;
		logic [READINGS-1:0]                inv;
		logic [READINGS-1:0][DIST_W-1:0]    distance;
	} upd_req_t;

	typedef struct packed {
		logic               busy;
		logic [COVER_W-1:0] nonzero;
	} tbl_stat_t;

	typedef struct packed {
		kind_t               kind;
		logic [ANGLE_W-1:0]  start_angle;
		logic [15:0]         rotation_speed;
		logic                checksum_ok;
		logic                index_ok;
		logic [READINGS-1:0] invalid_bits;
		logic [READINGS-1:0] warning_bits;
		logic [CNT_W-1:0]    good_total;
		logic [CNT_W-1:0]    bad_total;
		logic [COVER_W-1:0]  covered_angles;
		logic [DIST_W-1:0]   table_distance;
	} reply_t;

endpackage

// ===== hdl/lpp_if.sv =====
// Valid/ready channel interfaces for commands in and replies out.
// Depends on lpp_pkg.
`timescale 1ns / 1ps

interface lpp_in_if import lpp_pkg::*;;
	logic               valid;
	logic               ready;
	logic               command;
	logic [7:0]         rx_byte;
	logic [ANGLE_W-1:0] read_angle;

	modport source (output valid, command, rx_byte, read_angle, input ready);
	modport sink   (input valid, command, rx_byte, read_angle, output ready);
endinterface

interface lpp_out_if import lpp_pkg::*;;
	logic                valid;
	logic                ready;
	logic                reply_kind;
	logic [ANGLE_W-1:0]  start_angle;
	logic [15:0]         rotation_speed;
	logic                checksum_ok;
	logic                index_ok;
	logic [READINGS-1:0] invalid_bits;
	logic [READINGS-1:0] warning_bits;
	logic [CNT_W-1:0]    good_total;
	logic [CNT_W-1:0]    bad_total;
	logic [COVER_W-1:0]  covered_angles;
	logic [DIST_W-1:0]   table_distance;

	modport source (output valid, reply_kind, start_angle, rotation_speed, checksum_ok,
		index_ok, invalid_bits, warning_bits, good_total, bad_total, covered_angles,
		table_distance, input ready);
	modport sink   (input valid, reply_kind, start_angle, rotation_speed, checksum_ok,
		index_ok, invalid_bits, warning_bits, good_total, bad_total, covered_angles,
		table_distance, output ready);
endinterface

// ===== hdl/lpp_table.sv =====
// Distance table: one synchronous RAM, post-reset clearing sweep, and the
// four-step read-modify-write sequencer that keeps the nonzero entry count.
// Depends on lpp_pkg.
`timescale 1ns / 1ps

module lpp_table import lpp_pkg::*; #(
	parameter int TABLE_ANGLES = TABLE_ANGLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  upd_req_t           upd,
	input  logic               rd_en,
	input  logic [ANGLE_W-1:0] rd_angle,
	output logic [DIST_W-1:0]  rd_data,
	output tbl_stat_t          stat
);

	localparam int AW     = (TABLE_ANGLES > 1) ? $clog2(TABLE_ANGLES) : 1;
	localparam int STEP_W = $clog2(READINGS);
	localparam logic [AW-1:0]     LAST_ADDR = AW'(TABLE_ANGLES - 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(READINGS - 1);

	logic [DIST_W-1:0] mem [TABLE_ANGLES];

	logic               clearing_q;
	logic [AW-1:0]      clr_addr_q;
	upd_req_t           req_q;
	logic               rd_act_q;
	logic [STEP_W-1:0]  rd_step_q;
	logic               wr_v_q;
	logic [STEP_W-1:0]  wr_step_q;
	logic               wr_inr_q;
	logic [COVER_W-1:0] nonzero_q;

	logic [ANGLE_W-1:0] rd_ang;
	logic [ANGLE_W-1:0] wr_ang;
	logic               rd_inr;
	logic [DIST_W-1:0]  wr_val;
	logic               mem_we;
	logic               mem_re;
	logic [AW-1:0]      mem_wa;
	logic [AW-1:0]      mem_ra;
	logic [DIST_W-1:0]  mem_wd;

	assign rd_ang = req_q.start + ANGLE_W'(rd_step_q);
	assign wr_ang = req_q.start + ANGLE_W'(wr_step_q);
	assign rd_inr = 32'(rd_ang) < TABLE_ANGLES;
	assign wr_val = req_q.inv[wr_step_q] ? '0 : req_q.distance[wr_step_q];

	// the write of each angle follows its read in the next cycle; the four angles are distinct
	assign mem_we = clearing_q || (wr_v_q && wr_inr_q);
	assign mem_wa = clearing_q ? clr_addr_q : AW'(wr_ang);
	assign mem_wd = clearing_q ? '0 : wr_val;
	assign mem_re = rd_act_q ? rd_inr : rd_en;
	assign mem_ra = rd_act_q ? AW'(rd_ang) : AW'(rd_angle);

	assign stat.busy    = clearing_q || rd_act_q || wr_v_q;
	assign stat.nonzero = nonzero_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			rd_act_q   <= 1'b0;
			rd_step_q  <= '0;
			wr_v_q     <= 1'b0;
			nonzero_q  <= '0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == LAST_ADDR) begin
					clearing_q <= 1'b0;
				end
			end
			if (upd.valid) begin
				rd_act_q  <= 1'b1;
				rd_step_q <= '0;
			end else if (rd_act_q) begin
				rd_step_q <= rd_step_q + 1'b1;
				if (rd_step_q == LAST_STEP) begin
					rd_act_q <= 1'b0;
				end
			end
			wr_v_q <= rd_act_q;
			if (!clearing_q && wr_v_q && wr_inr_q) begin
				if (rd_data != '0 && wr_val == '0) begin
					nonzero_q <= nonzero_q - 1'b1;
				end else if (rd_data == '0 && wr_val != '0) begin
					nonzero_q <= nonzero_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.valid) begin
			req_q <= upd;
		end
		wr_step_q <= rd_step_q;
		wr_inr_q  <= rd_inr;
	end

endmodule

// ===== hdl/lidar_packet_parser.sv =====
// Top level of the distance packet parser: framing, checksum, decode,
// counters and the reply register. Depends on lpp_pkg, lpp_if, lpp_table.
`timescale 1ns / 1ps

// Byte-stream parser for a spinning range sensor. Each req transaction is
// either one received serial byte (command 0) or a distance table read
// (command 1). Bytes are framed into 22-byte packets that open with 0xFA;
// the last byte of a packet yields one summary transaction on rsp, a read
// yields one read reply, other bytes yield nothing. Bytes and reads are taken
// one per cycle while rsp keeps up; a single output register lets the next
// transaction in while a reply waits. While the last byte of a packet sits
// in stage 1 req.ready is low; after a packet with a good index it stays low
// while the table sequencer reads, compares and writes the four angles (one
// RAM port each way, registered read data). After reset the table RAM is
// swept to zero, one entry per cycle (all TABLE_ANGLES entries, 360 by
// default); req.ready stays low until then.
module lidar_packet_parser import lpp_pkg::*; #(
	parameter int TABLE_ANGLES = TABLE_ANGLES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lpp_in_if.sink     req,
	lpp_out_if.source  rsp
);

	// stage 1: the accepted transaction, table read data arrives here
	logic               valid_s1;
	cmd_t               cmd_s1;
	logic [7:0]         byte_s1;
	logic               rd_inr_s1;

	// framing state
	logic               hunting_q;
	logic [POS_W-1:0]   pos_q;
	logic [CSUM_W-1:0]  acc_q;
	logic [7:0]         prev_q;
	logic [7:0]         pkt_q [PACKET_BYTES-1];

	// counters
	logic [CNT_W-1:0]   good_q;
	logic [CNT_W-1:0]   bad_q;
	logic [COVER_W-1:0] covered_q;

	// reply register
	logic               out_valid_q;
	reply_t             out_q;

	upd_req_t           upd;
	tbl_stat_t          stat;
	logic [DIST_W-1:0]  rd_data;
	logic               rd_en;
	logic               in_acc;
	logic               rd_inr;

	logic               sync;
	logic               s1_eop;
	logic               s1_has_res;
	logic               s1_go;
	logic               out_free;

	// packet decode
	logic [15:0]        recv_sum;
	logic [CSUM_FOLD:0] fold_sum;
	logic               csum_ok;
	logic               idx_ok;
	logic [7:0]         idx_off;
	logic [ANGLE_W-1:0] start;
	logic [READINGS-1:0] inv;
	logic [READINGS-1:0] warn;
	logic [READINGS-1:0][DIST_W-1:0] distances;
	logic [2:0]         n_good;
	logic [2:0]         n_bad;
	logic [CNT_W-1:0]   base_good;
	logic [CNT_W-1:0]   base_bad;
	logic [CNT_W-1:0]   good_new;
	logic [CNT_W-1:0]   bad_new;
	logic [COVER_W-1:0] covered_new;
	reply_t             reply;

	lpp_table #(
		.TABLE_ANGLES (TABLE_ANGLES)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.rd_en    (rd_en),
		.rd_angle (req.read_angle),
		.rd_data  (rd_data),
		.stat     (stat)
	);

	// ---------------- handshake ----------------
	assign sync       = hunting_q || pos_q == '0 || pos_q >= POS_W'(PACKET_BYTES);
	assign s1_eop     = cmd_s1 == CMD_BYTE && !sync && pos_q == POS_W'(PACKET_BYTES - 1);
	assign s1_has_res = cmd_s1 == CMD_READ || s1_eop;
	assign out_free   = !out_valid_q || rsp.ready;
	assign s1_go      = valid_s1 && (!s1_has_res || out_free);

	// no new transaction while the table is busy or the last byte of a packet sits in stage 1
	assign req.ready = !stat.busy && (!valid_s1 || (s1_go && !s1_eop));
	assign in_acc    = req.valid && req.ready;
	assign rd_inr    = 32'(req.read_angle) < TABLE_ANGLES;
	assign rd_en     = in_acc && cmd_t'(req.command) == CMD_READ && rd_inr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1    <= cmd_t'(req.command);
			byte_s1   <= req.rx_byte;
			rd_inr_s1 <= rd_inr;
		end
	end

	// ---------------- packet decode ----------------
	// checksum: 26-bit shift-and-add, folded to 15 bits
	assign recv_sum = {byte_s1, pkt_q[CSUM_BYTES_AT]};
	assign fold_sum = (CSUM_FOLD + 1)'(acc_q[CSUM_FOLD-1:0])
		+ (CSUM_FOLD + 1)'(acc_q[CSUM_W-1:CSUM_FOLD]);
	assign csum_ok  = recv_sum == {1'b0, fold_sum[CSUM_FOLD-1:0]};

	assign idx_ok  = pkt_q[1] >= INDEX_BASE && pkt_q[1] <= INDEX_LAST;
	assign idx_off = pkt_q[1] - INDEX_BASE;
	assign start   = idx_ok ? {idx_off[ANGLE_W-3:0], 2'b00} : '0;

	always_comb begin
		n_good = '0;
		n_bad  = '0;
		for (int i = 0; i < READINGS; i++) begin
			inv[i]       = pkt_q[5 + 4 * i][INV_BIT];
			warn[i]      = pkt_q[5 + 4 * i][WARN_BIT];
			distances[i] = {pkt_q[5 + 4 * i][DIST_HI_W-1:0], pkt_q[4 + 4 * i]};
			n_good       = n_good + 3'(!inv[i]);
			n_bad        = n_bad + 3'(inv[i]);
		end
	end

	// index-0 packet: latch coverage, clear both counts (also the checksum penalty)
	always_comb begin
		base_good   = good_q;
		base_bad    = csum_ok ? bad_q : bad_q + CNT_W'(BAD_CSUM_PENALTY);
		covered_new = covered_q;
		if (start == '0) begin
			base_good   = '0;
			base_bad    = '0;
			covered_new = stat.nonzero;
		end
		good_new = base_good + CNT_W'(n_good);
		bad_new  = base_bad + CNT_W'(n_bad);
		if (!idx_ok) begin
			good_new    = good_q;
			bad_new     = bad_q;
			covered_new = covered_q;
		end
	end

	assign upd.valid    = s1_go && s1_eop && idx_ok;
	assign upd.start    = start;
	assign upd.inv      = inv;
	assign upd.distance = distances;

	// ---------------- framing and counters ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunting_q <= 1'b1;
			pos_q     <= '0;
			acc_q     <= '0;
			good_q    <= '0;
			bad_q     <= '0;
			covered_q <= '0;
		end else if (s1_go && cmd_s1 == CMD_BYTE) begin
			if (sync) begin
				if (byte_s1 == START_BYTE) begin
					hunting_q <= 1'b0;
					pos_q     <= POS_W'(1);
					acc_q     <= '0;
				end else begin
					hunting_q <= 1'b1;
					pos_q     <= '0;
				end
			end else begin
				// odd positions below the checksum close a 16-bit word
				if (pos_q[0] && pos_q < POS_W'(CSUM_BYTES_AT)) begin
					acc_q <= {acc_q[CSUM_W-2:0], 1'b0} + CSUM_W'({byte_s1, prev_q});
				end
				if (s1_eop) begin
					hunting_q <= 1'b1;
					pos_q     <= '0;
					good_q    <= good_new;
					bad_q     <= bad_new;
					covered_q <= covered_new;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && cmd_s1 == CMD_BYTE) begin
			prev_q <= byte_s1;
			if (sync) begin
				pkt_q[0] <= byte_s1;
			end else if (!s1_eop) begin
				pkt_q[pos_q] <= byte_s1;
			end
		end
	end

	// ---------------- reply ----------------
	always_comb begin
		reply = '0;
		if (cmd_s1 == CMD_READ) begin
			reply.kind           = KIND_READ;
			reply.table_distance = rd_inr_s1 ? rd_data : '0;
		end else begin
			reply.kind           = KIND_SUMMARY;
			reply.start_angle    = start;
			reply.rotation_speed = {pkt_q[3], pkt_q[2]};
			reply.checksum_ok    = csum_ok;
			reply.index_ok       = idx_ok;
			reply.invalid_bits   = inv;
			reply.warning_bits   = warn;
			reply.good_total     = good_new;
			reply.bad_total      = bad_new;
			reply.covered_angles = covered_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && s1_has_res) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_has_res) begin
			out_q <= reply;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.reply_kind     = out_q.kind;
	assign rsp.start_angle    = out_q.start_angle;
	assign rsp.rotation_speed = out_q.rotation_speed;
	assign rsp.checksum_ok    = out_q.checksum_ok;
	assign rsp.index_ok       = out_q.index_ok;
	assign rsp.invalid_bits   = out_q.invalid_bits;
	assign rsp.warning_bits   = out_q.warning_bits;
	assign rsp.good_total     = out_q.good_total;
	assign rsp.bad_total      = out_q.bad_total;
	assign rsp.covered_angles = out_q.covered_angles;
	assign rsp.table_distance = out_q.table_distance;

endmodule
